### src/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared phase codes, result kinds and the result record of the packet
// deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CSUM   = 3'd3;
  localparam logic [2:0] PH_TRAIL1 = 3'd4;
  localparam logic [2:0] PH_TRAIL2 = 3'd5;

  localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
  localparam logic [2:0] KIND_BAD_START  = 3'd1;
  localparam logic [2:0] KIND_BAD_CSUM   = 3'd2;
  localparam logic [2:0] KIND_BAD_TRAIL1 = 3'd3;
  localparam logic [2:0] KIND_END        = 3'd4;

  localparam logic [1:0] REASON_GOOD       = 2'd0;
  localparam logic [1:0] REASON_EARLY_ERR  = 2'd1;
  localparam logic [1:0] REASON_BAD_TRAIL2 = 2'd2;

  localparam logic [7:0] START_BYTE_RESET = 8'h50;
  localparam logic [7:0] CSUM_INVERT      = 8'hff;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       last_payload;
    logic [7:0] frame_length;
    logic       frame_good;
    logic [1:0] end_reason;
  } result_t;

endpackage

### src/cpd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// cpd_frame_ctrl
// Frame state and per-byte decode: consumes one registered byte per step and
// produces at most one result item.
// ----------------------------------------------------------------------------
module cpd_frame_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       start_byte,
  output logic             res_valid,
  output cpd_pkg::result_t res
);

  logic [2:0] phase_r,       phase_nxt;
  logic [7:0] bytes_left_r,  bytes_left_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       still_valid_r, still_valid_nxt;
  logic [7:0] length_seen_r, length_seen_nxt;
  logic [7:0] payload_pos_r, payload_pos_nxt;
  logic       csum_ok;

  assign csum_ok = (rx_byte == (running_sum_r ^ cpd_pkg::CSUM_INVERT));

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    still_valid_nxt = still_valid_r;
    length_seen_nxt = length_seen_r;
    payload_pos_nxt = payload_pos_r;
    res_valid       = 1'b0;
    res             = '0;
    unique case (phase_r)
      cpd_pkg::PH_LEN: begin
        length_seen_nxt = rx_byte;
        bytes_left_nxt  = rx_byte;
        running_sum_nxt = running_sum_r + rx_byte;
        phase_nxt       = cpd_pkg::PH_DATA;
      end
      cpd_pkg::PH_DATA: begin
        res_valid          = 1'b1;
        res.kind           = cpd_pkg::KIND_PAYLOAD;
        res.payload_byte   = rx_byte;
        res.byte_index     = payload_pos_r;
        res.last_payload   = (bytes_left_r == 8'd0);
        res.frame_length   = length_seen_r;
        running_sum_nxt    = running_sum_r + rx_byte;
        payload_pos_nxt    = payload_pos_r + 8'd1;
        if (bytes_left_r == 8'd0) begin
          phase_nxt = cpd_pkg::PH_CSUM;
        end else begin
          bytes_left_nxt = bytes_left_r - 8'd1;
        end
      end
      cpd_pkg::PH_CSUM: begin
        still_valid_nxt  = csum_ok;
        res_valid        = !csum_ok;
        res.kind         = cpd_pkg::KIND_BAD_CSUM;
        res.frame_length = length_seen_r;
        phase_nxt        = cpd_pkg::PH_TRAIL1;
      end
      cpd_pkg::PH_TRAIL1: begin
        if (rx_byte != 8'd0) begin
          still_valid_nxt = 1'b0;
        end
        res_valid        = (rx_byte != 8'd0);
        res.kind         = cpd_pkg::KIND_BAD_TRAIL1;
        res.frame_length = length_seen_r;
        phase_nxt        = cpd_pkg::PH_TRAIL2;
      end
      cpd_pkg::PH_TRAIL2: begin
        res_valid        = 1'b1;
        res.kind         = cpd_pkg::KIND_END;
        res.frame_length = length_seen_r;
        if (!still_valid_r) begin
          res.end_reason = cpd_pkg::REASON_EARLY_ERR;
        end else if (rx_byte != 8'd0) begin
          res.end_reason = cpd_pkg::REASON_BAD_TRAIL2;
        end else begin
          res.end_reason = cpd_pkg::REASON_GOOD;
        end
        res.frame_good   = still_valid_r && (rx_byte == 8'd0);
        phase_nxt        = cpd_pkg::PH_START;
      end
      default: begin
        // awaiting start, unused codes included
        if (rx_byte != start_byte) begin
          res_valid = 1'b1;
          res.kind  = cpd_pkg::KIND_BAD_START;
          phase_nxt = cpd_pkg::PH_START;
        end else begin
          running_sum_nxt = rx_byte;
          payload_pos_nxt = 8'd0;
          phase_nxt       = cpd_pkg::PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cpd_pkg::PH_START;
      bytes_left_r  <= 8'd0;
      running_sum_r <= 8'd0;
      still_valid_r <= 1'b0;
      length_seen_r <= 8'd0;
      payload_pos_r <= 8'd0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_sum_r <= running_sum_nxt;
      still_valid_r <= still_valid_nxt;
      length_seen_r <= length_seen_nxt;
      payload_pos_r <= payload_pos_nxt;
    end
  end

  a_last_to_csum: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && phase_r == cpd_pkg::PH_DATA && bytes_left_r == 8'd0)
    |=> (phase_r == cpd_pkg::PH_CSUM))
    else $error("last payload byte did not move to checksum");

  a_good_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == cpd_pkg::KIND_END)
    |-> (res.frame_good == (res.end_reason == cpd_pkg::REASON_GOOD)))
    else $error("frame verdict disagrees with end reason");

  a_pos_clear_at_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cpd_pkg::PH_LEN) |-> (payload_pos_r == 8'd0))
    else $error("payload position not cleared at frame start");

endmodule

### src/cpd_out_stage.sv
// ----------------------------------------------------------------------------
// cpd_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module cpd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cpd_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output cpd_pkg::result_t res_q
);

  logic             valid_r;
  cpd_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !load)
    else $error("pending result item overwritten");

endmodule

### src/checksummed_packet_deframer.sv
// ----------------------------------------------------------------------------
// checksummed_packet_deframer
// Splits a received byte stream into start/length/payload/checksum/trailer
// frames, passing payload bytes on and reporting errors and frame verdicts.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid/in_ready    in_rx_byte
//   out      out_valid/out_ready  out_result_kind .. out_end_reason
//   cfg      cfg_we               cfg_wdata (start byte)
//
// one item per cycle sustained while no result waits on out_ready; the result
// passes the input register, then the result register
// a byte that gives no result retires even while the result register is held
// reset is synchronous, active low; start byte returns to ascii P
// ----------------------------------------------------------------------------
module checksummed_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_byte_index,
  output logic       out_last_payload,
  output logic [7:0] out_frame_length,
  output logic       out_frame_good,
  output logic [1:0] out_end_reason,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic [7:0]       start_byte_r;
  logic             res_valid;
  cpd_pkg::result_t res;
  cpd_pkg::result_t res_q;
  logic             out_free;
  logic             advance;
  logic             step_en;

  assign advance  = !res_valid || out_free;
  assign step_en  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= cpd_pkg::START_BYTE_RESET;
    end else if (cfg_we) begin
      start_byte_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  cpd_frame_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .rx_byte    (s1_byte_r),
    .start_byte (start_byte_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  cpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_q     (res_q)
  );

  assign out_result_kind  = res_q.kind;
  assign out_payload_byte = res_q.payload_byte;
  assign out_byte_index   = res_q.byte_index;
  assign out_last_payload = res_q.last_payload;
  assign out_frame_length = res_q.frame_length;
  assign out_frame_good   = res_q.frame_good;
  assign out_end_reason   = res_q.end_reason;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !in_ready) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("stalled item lost from input register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> (res_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

endmodule
